// File: rtl/i2d_pkg.sv
package i2d_pkg;

  // result field widths
  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 4;

  // magnitude bits folded into the BCD register per converter cycle
  localparam int STEP_BITS = 4;

  // log10(2) as a ratio, for sizing the BCD register at elaboration
  localparam int LOG2_NUM = 30103;
  localparam int LOG2_DEN = 100000;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // double-dabble correction of one BCD digit before a shift
  function automatic logic [DIGIT_W-1:0] bcd_adj(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
    return r;
  endfunction

endpackage

// File: rtl/integer_to_decimal_digits.sv
// integer_to_decimal_digits: signed integer in, decimal digits of its magnitude out.
//
// Input: drive in_value and raise start; the transfer happens at the rising edge
// where start is high and busy is low. busy is high only while the two-entry
// input queue is full.
// Output: one digit per cycle, most significant first, each shown for exactly one
// cycle with out_valid high. Every digit of an item carries out_digit_count, and
// out_last marks the least significant one. Digits of one item come back to back.
// The sign is dropped; zero gives one digit 0; no leading zeros.
// The value goes through the two-entry input queue to the converter, which folds
// 4 magnitude bits per cycle into a BCD register; the emitter then registers each
// digit onto the outputs. Digits stream out while the next item converts.
// The receiver cannot stall; out_valid is never held off.
// Reset (synchronous, rst_n low) empties the queue and drops any item in flight.
module integer_to_decimal_digits #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  output logic                          out_valid,
  output logic [i2d_pkg::DIGIT_W-1:0]   out_digit,
  output logic [i2d_pkg::COUNT_W-1:0]   out_digit_count,
  output logic                          out_last
);

  // digits needed for any VALUE_BITS-bit magnitude
  localparam int BCD_DIGITS = (VALUE_BITS * i2d_pkg::LOG2_NUM) / i2d_pkg::LOG2_DEN + 1;
  localparam int BW         = BCD_DIGITS * i2d_pkg::DIGIT_W;

  i2d_pkg::fifo_stat_t   q_stat;
  logic                  q_push, q_pop;
  logic [VALUE_BITS-1:0] q_wdata, q_rdata;
  logic                  cv_done, em_take;
  logic [BW-1:0]         cv_bcd;

  // front: magnitude and queue write
  i2d_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .start    (start),
    .busy     (busy),
    .in_value (in_value),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  i2d_fifo #(.WIDTH(VALUE_BITS)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  // back: iterative binary to BCD, then digit streaming
  i2d_conv #(.VALUE_BITS(VALUE_BITS), .BCD_DIGITS(BCD_DIGITS)) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_data (q_rdata),
    .q_pop  (q_pop),
    .done   (cv_done),
    .bcd    (cv_bcd),
    .take   (em_take)
  );

  i2d_emit #(.BCD_DIGITS(BCD_DIGITS), .MAX_DIGITS(MAX_DIGITS)) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .done            (cv_done),
    .bcd             (cv_bcd),
    .take            (em_take),
    .out_valid       (out_valid),
    .out_digit       (out_digit),
    .out_digit_count (out_digit_count),
    .out_last        (out_last)
  );

  // decimal digits only
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit <= i2d_pkg::DIGIT_W'(9)))
    else $error("digit out of range");

  // an item's digits stream without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside an item's digits");

  // digit count constant across one item
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> $stable(out_digit_count))
    else $error("digit count changed within an item");

  // converter hands off only when it has a result
  a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
    em_take |-> cv_done)
    else $error("handoff without converted result");

endmodule

// File: rtl/i2d_fifo.sv
module i2d_fifo #(
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output i2d_pkg::fifo_stat_t  stat
);

  // two-entry queue between front and converter
  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// File: rtl/i2d_front.sv
module i2d_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                   start,
  output logic                   busy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  i2d_pkg::fifo_stat_t    q_stat,
  output logic                   q_push,
  output logic [VALUE_BITS-1:0]  q_data
);

  logic [VALUE_BITS-1:0] raw;

  // sign dropped here; the most negative value wraps to its true magnitude
  assign raw    = in_value;
  assign q_data = raw[VALUE_BITS-1]
                  ? (~raw) + {{(VALUE_BITS-1){1'b0}}, 1'b1}
                  : raw;
  assign busy   = q_stat.full;
  assign q_push = start && !q_stat.full;

endmodule

// File: rtl/i2d_conv.sv
module i2d_conv #(
  parameter int VALUE_BITS = 32,
  parameter int BCD_DIGITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  i2d_pkg::fifo_stat_t     q_stat,
  input  logic [VALUE_BITS-1:0]   q_data,
  output logic                    q_pop,
  output logic                    done,
  output logic [BCD_DIGITS*i2d_pkg::DIGIT_W-1:0] bcd,
  input  logic                    take
);

  localparam int STEPS = (VALUE_BITS + i2d_pkg::STEP_BITS - 1) / i2d_pkg::STEP_BITS;
  localparam int PAD   = STEPS * i2d_pkg::STEP_BITS;
  localparam int BW    = BCD_DIGITS * i2d_pkg::DIGIT_W;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [2:0] {
    CV_IDLE = 3'b001,
    CV_RUN  = 3'b010,
    CV_HOLD = 3'b100
  } cv_state_t;

  cv_state_t      st_r, st_nxt;
  logic [PAD-1:0] sh_r, sh_nxt;
  logic [BW-1:0]  bcd_r, bcd_nxt;
  logic [SW-1:0]  step_r, step_nxt;
  logic [BW-1:0]  b;
  logic [PAD-1:0] s;
  logic           load;

  // four shift-and-correct steps per cycle; digits are corrected independently
  always_comb begin
    b = bcd_r;
    s = sh_r;
    for (int k = 0; k < i2d_pkg::STEP_BITS; k++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        b[d*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W] =
          i2d_pkg::bcd_adj(b[d*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W]);
      end
      {b, s} = {b[BW-2:0], s, 1'b0};
    end
  end

  assign load  = !q_stat.empty && ((st_r == CV_IDLE) || ((st_r == CV_HOLD) && take));
  assign q_pop = load;
  assign done  = (st_r == CV_HOLD);
  assign bcd   = bcd_r;

  always_comb begin
    st_nxt   = st_r;
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    step_nxt = step_r;
    unique case (st_r)
      CV_IDLE: begin
      end
      CV_RUN: begin
        sh_nxt   = s;
        bcd_nxt  = b;
        step_nxt = step_r - SW'(1);
        if (step_r == '0) begin
          st_nxt = CV_HOLD;
        end
      end
      CV_HOLD: begin
        if (take) begin
          st_nxt = CV_IDLE;
        end
      end
      default: st_nxt = CV_IDLE;
    endcase
    if (load) begin
      st_nxt   = CV_RUN;
      sh_nxt   = PAD'(q_data);
      bcd_nxt  = '0;
      step_nxt = SW'(STEPS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= CV_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    bcd_r  <= bcd_nxt;
    step_r <= step_nxt;
  end

endmodule

// File: rtl/i2d_emit.sv
module i2d_emit #(
  parameter int BCD_DIGITS = 10,
  parameter int MAX_DIGITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               done,
  input  logic [BCD_DIGITS*i2d_pkg::DIGIT_W-1:0] bcd,
  output logic                               take,
  output logic                               out_valid,
  output logic [i2d_pkg::DIGIT_W-1:0]        out_digit,
  output logic [i2d_pkg::COUNT_W-1:0]        out_digit_count,
  output logic                               out_last
);

  localparam int BW  = BCD_DIGITS * i2d_pkg::DIGIT_W;
  localparam int CW  = $clog2(BCD_DIGITS + 1);
  localparam int IW  = $clog2(BCD_DIGITS);
  localparam int LIM = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;

  logic [BW-1:0]  dig_r, dig_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic           act_r, act_nxt;
  logic           ov_r, ov_nxt;
  logic [i2d_pkg::DIGIT_W-1:0] od_r, od_nxt;
  logic [i2d_pkg::COUNT_W-1:0] oc_r, oc_nxt;
  logic           ol_r, ol_nxt;
  logic [CW-1:0]  cnt, ncl;

  // digit count: position of the highest nonzero digit, at least one
  always_comb begin
    cnt = CW'(1);
    for (int d = 1; d < BCD_DIGITS; d++) begin
      if (bcd[d*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W] != '0) begin
        cnt = CW'(d + 1);
      end
    end
    ncl = (cnt > CW'(LIM)) ? CW'(LIM) : cnt;
  end

  assign take = done && (!act_r || (idx_r == '0));

  always_comb begin
    dig_nxt = dig_r;
    idx_nxt = idx_r;
    n_nxt   = n_r;
    act_nxt = act_r;
    ov_nxt  = 1'b0;
    od_nxt  = od_r;
    oc_nxt  = oc_r;
    ol_nxt  = 1'b0;
    if (act_r) begin
      ov_nxt  = 1'b1;
      od_nxt  = dig_r[idx_r*i2d_pkg::DIGIT_W +: i2d_pkg::DIGIT_W];
      oc_nxt  = i2d_pkg::COUNT_W'(n_r);
      ol_nxt  = (idx_r == '0);
      idx_nxt = idx_r - IW'(1);
      if (idx_r == '0) begin
        act_nxt = 1'b0;
      end
    end
    if (take) begin
      dig_nxt = bcd;
      n_nxt   = ncl;
      idx_nxt = IW'(ncl - CW'(1));
      act_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
    od_r  <= od_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_digit       = od_r;
  assign out_digit_count = oc_r;
  assign out_last        = ol_r;

endmodule

// File: test/integer_to_decimal_digits_tb.sv
`timescale 1ns / 1ps

module integer_to_decimal_digits_tb;

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 10;
  // Generous: many times what ~120 transfers need.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 98;
  localparam int DRAIN_CYCLES = 24;  // quiet window after the last predicted digit

  // One expected digit result.
  typedef struct packed {
    logic [i2d_pkg::DIGIT_W-1:0] digit;
    logic [i2d_pkg::COUNT_W-1:0] count;
    logic                        last;
  } digit_rec_t;

  // Scoreboard: turns each accepted value into its digit sequence and checks
  // every strobed digit against the oldest pending one.
  class digit_scoreboard;
    digit_rec_t pending_digits[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Predict the digits of one transferred value, most significant first.
    function void note_value(input logic signed [VALUE_BITS-1:0] v);
      logic [VALUE_BITS:0]          mag;
      logic [i2d_pkg::DIGIT_W-1:0]  lsd_first[$];
      digit_rec_t                   rec;
      int                           n;
      // Sign-extend by one bit so the most negative value negates cleanly.
      mag = {v[VALUE_BITS-1], v};
      if (v[VALUE_BITS-1]) mag = -mag;
      do begin
        lsd_first = {lsd_first, i2d_pkg::DIGIT_W'(mag % 10)};
        mag = mag / 10;
      end while (mag != 0);
      // Over-long magnitudes keep only the low-order digits.
      while (lsd_first.size() > MAX_DIGITS) lsd_first.pop_back();
      n = lsd_first.size();
      for (int k = n - 1; k >= 0; k--) begin
        rec.digit = lsd_first[k];
        rec.count = i2d_pkg::COUNT_W'(n);
        rec.last  = (k == 0);
        pending_digits = {pending_digits, rec};
      end
    endfunction

    function void check_digit(input logic [i2d_pkg::DIGIT_W-1:0] digit,
                              input logic [i2d_pkg::COUNT_W-1:0] count,
                              input logic last);
      digit_rec_t want;
      if (pending_digits.size() == 0) begin
        if (errors < 10)
          $display("unexpected digit %0d count %0d last %0b", digit, count, last);
        errors++;
        return;
      end
      want = pending_digits.pop_front();
      if (digit !== want.digit || count !== want.count || last !== want.last) begin
        if (errors < 10)
          $display("digit mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b (digit/count/last)",
                   want.digit, want.count, want.last, digit, count, last);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         out_valid;
  logic [i2d_pkg::DIGIT_W-1:0]  out_digit;
  logic [i2d_pkg::COUNT_W-1:0]  out_digit_count;
  logic                         out_last;

  digit_scoreboard sb;
  int              cycles = 0;

  integer_to_decimal_digits #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_digit(out_digit),
    .out_digit_count(out_digit_count),
    .out_last(out_last)
  );

  // 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: any hang ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Monitor. Both sides are sampled at the rising edge, before any NBA of that
  // step lands, so we see exactly what the block saw. The result is checked
  // before the input transfer is noted: a digit can never belong to a value
  // transferred at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_digit(out_digit, out_digit_count, out_last);
      if (start && !busy) sb.note_value(in_value);
    end
  end

  function automatic longint unsigned pow10(input int e);
    longint unsigned p;
    p = 1;
    repeat (e) p = p * 10;
    return p;
  endfunction

  // One input transfer: random idle gap (start low), then hold start with the
  // value until the block takes it. Back-to-back items keep start high, so
  // start is never dropped and re-raised in the same step.
  task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Random value with a chosen digit length and random sign.
  function automatic logic signed [VALUE_BITS-1:0] value_of_length(input int nd);
    longint unsigned lo, hi, mag;
    lo = (nd == 1) ? 0 : pow10(nd - 1);
    hi = pow10(nd) - 1;
    if (hi > 64'd2147483647) hi = 64'd2147483647;
    mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
    return $urandom_range(0, 1) ? -VALUE_BITS'(mag) : VALUE_BITS'(mag);
  endfunction

  logic signed [VALUE_BITS-1:0] directed_values [] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    32'sd999999999, 32'sd1000000000, -32'sd1000000000, 32'sd1234567890,
    32'sh7fffffff, 32'sh80000000, 32'sh80000001, 32'sh55555555, 32'shaaaaaaaa,
    32'sd7, 32'sd5, -32'sd8, 32'sd3
  };

  initial begin
    logic signed [VALUE_BITS-1:0] v;
    int                           kind;
    int                           wait_cycles;

    sb       = new();
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, single digits, decade edges, both signed extremes
    // (most negative has no positive twin), alternating bit patterns.
    foreach (directed_values[i]) send_value(directed_values[i]);

    // Random: mostly length-targeted so every digit count shows up often,
    // plus full-range words (all bits toggle) and values next to powers of ten.
    repeat (RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        v = value_of_length($urandom_range(1, MAX_DIGITS));
      end else if (kind < 85) begin
        v = $urandom;
      end else begin
        v = VALUE_BITS'(pow10($urandom_range(1, 9)));
        v = v + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      send_value(v);
    end
    start <= 1'b0;

    // Drain: wait for every predicted digit (watchdog bounds this), then
    // a short quiet window to catch stray strobes.
    while (sb.pending_digits.size() != 0) @(posedge clk);
    wait_cycles = DRAIN_CYCLES;
    repeat (wait_cycles) @(posedge clk);

    if (sb.pending_digits.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/i2d_pkg.sv
rtl/i2d_fifo.sv
rtl/i2d_front.sv
rtl/i2d_conv.sv
rtl/i2d_emit.sv
rtl/integer_to_decimal_digits.sv
test/integer_to_decimal_digits_tb.sv
